@@ sv/alm_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_pkg
// Shared types, constants and the log2 fraction table builder for the audio
// level meter.
// ----------------------------------------------------------------------------
package alm_pkg;

  localparam int COUNT_BITS_DEF     = 18;
  localparam int LOG_TABLE_BITS_DEF = 6;
  localparam int FRAC_BITS          = 16;
  localparam int FS_LOG2            = 23;

  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 12;

  localparam logic [22:0] DB16_PER_OCT = 23'd6313057;
  localparam logic [23:0] RMS_LIMIT    = 24'h800000;
  localparam logic [15:0] DIV5_RECIP   = 16'd52429;
  localparam logic [12:0] LEVEL_SAT    = 13'd1920;
  localparam logic signed [11:0] LEVEL_MIN = -12'sd1920;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLIP  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NOISE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_OK    = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WEAK  = 2'd3;

  typedef enum logic [2:0] {
    VD_NO_DATA = 3'd0,
    VD_CLIP    = 3'd1,
    VD_NOISY   = 3'd2,
    VD_OK      = 3'd3,
    VD_WEAK    = 3'd4,
    VD_WAIT    = 3'd5
  } verdict_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SQ,
    ST_ROOT_GO,
    ST_ROOT,
    ST_LV_NORM,
    ST_LV_RND,
    ST_FMUL,
    ST_OUT
  } state_t;

  typedef enum logic [1:0] {
    RT_IDLE,
    RT_DIV,
    RT_SQRT
  } root_state_t;

  // 16 fractional bits of log2(1 + idx/2^tbits) by repeated squaring in Q30
  function automatic logic [15:0] alm_frac_entry(input int idx, input int tbits);
    logic [63:0] x;
    logic [15:0] f;
    x = ((64'd1 << tbits) + 64'(idx)) << (30 - tbits);
    f = '0;
    for (int k = 0; k < FRAC_BITS; k++) begin
      x = (x * x) >> 30;
      f = {f[14:0], 1'b0};
      if (x >= (64'd2 << 30)) begin
        f[0] = 1'b1;
        x    = x >> 1;
      end
    end
    return f;
  endfunction

endpackage

@@ sv/alm_in_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_in_if
// Input channel: audio sample words and report ticks.
// ----------------------------------------------------------------------------
interface alm_in_if;
  logic               valid;
  logic               ready;
  logic               func;
  logic signed [31:0] raw_word;

  modport source (output valid, output func, output raw_word, input ready);
  modport sink   (input valid, input func, input raw_word, output ready);
endinterface

@@ sv/alm_out_if.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_out_if
// Result channel: one level report per non-empty window.
// ----------------------------------------------------------------------------
interface alm_out_if;
  logic               valid;
  logic               ready;
  logic [23:0]        rms_value;
  logic signed [11:0] rms_level;
  logic signed [11:0] peak_level;
  logic signed [11:0] noise_floor;
  logic signed [11:0] level_rise;
  logic [17:0]        nonzero_samples;
  logic [17:0]        window_samples;
  logic [2:0]         verdict;

  modport source (output valid, output rms_value, output rms_level, output peak_level,
                  output noise_floor, output level_rise, output nonzero_samples,
                  output window_samples, output verdict, input ready);
  modport sink   (input valid, input rms_value, input rms_level, input peak_level,
                  input noise_floor, input level_rise, input nonzero_samples,
                  input window_samples, input verdict, output ready);
endinterface

@@ sv/alm_root.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// alm_root
// Mean-square root engine: restoring divide of the square sum by the sample
// count, then a bit-pair square root, both on one shared 64-bit subtractor.
// ----------------------------------------------------------------------------
module alm_root #(
  parameter int COUNT_BITS = alm_pkg::COUNT_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  start,
  input  logic [63:0]           sum,
  input  logic [COUNT_BITS-1:0] count,
  output logic                  done,
  output logic [23:0]           rms
);
  import alm_pkg::*;

  root_state_t           st_r, st_nxt;
  logic [COUNT_BITS-1:0] rem_r, rem_nxt;
  logic [COUNT_BITS-1:0] div_r, div_nxt;
  logic [63:0]           q_r, q_nxt;
  logic [63:0]           r_r, r_nxt;
  logic [63:0]           bit_r, bit_nxt;
  logic [5:0]            cnt_r, cnt_nxt;
  logic                  done_r, done_nxt;
  logic [23:0]           rms_r, rms_nxt;

  logic [63:0]           sub_a, sub_b, sub_d;
  logic                  sub_borrow, sub_ge;
  logic [COUNT_BITS:0]   div_try;
  logic [63:0]           r_step;

  // shared subtractor
  assign {sub_borrow, sub_d} = {1'b0, sub_a} - {1'b0, sub_b};
  assign sub_ge = !sub_borrow;

  assign div_try = {rem_r, q_r[63]};

  always_comb begin
    st_nxt   = st_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;
    r_nxt    = r_r;
    bit_nxt  = bit_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    rms_nxt  = rms_r;
    sub_a    = 64'(div_try);
    sub_b    = 64'(div_r);
    r_step   = '0;
    unique case (st_r)
      RT_IDLE: begin
        if (start) begin
          q_nxt   = sum;
          div_nxt = count;
          rem_nxt = '0;
          cnt_nxt = 6'd63;
          st_nxt  = RT_DIV;
        end
      end
      RT_DIV: begin
        // one quotient bit a cycle
        if (sub_ge) begin
          rem_nxt = sub_d[COUNT_BITS-1:0];
          q_nxt   = {q_r[62:0], 1'b1};
        end else begin
          rem_nxt = div_try[COUNT_BITS-1:0];
          q_nxt   = {q_r[62:0], 1'b0};
        end
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          r_nxt   = '0;
          bit_nxt = 64'd1 << 62;
          cnt_nxt = 6'd31;
          st_nxt  = RT_SQRT;
        end
      end
      RT_SQRT: begin
        // one root bit a cycle; r and bit never overlap
        sub_a = q_r;
        sub_b = r_r | bit_r;
        if (sub_ge) begin
          q_nxt  = sub_d;
          r_step = (r_r >> 1) | bit_r;
        end else begin
          r_step = r_r >> 1;
        end
        r_nxt   = r_step;
        bit_nxt = bit_r >> 2;
        cnt_nxt = cnt_r - 6'd1;
        if (cnt_r == '0) begin
          rms_nxt  = (r_step > 64'(RMS_LIMIT)) ? RMS_LIMIT : r_step[23:0];
          done_nxt = 1'b1;
          st_nxt   = RT_IDLE;
        end
      end
      default: st_nxt = RT_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r   <= RT_IDLE;
      done_r <= 1'b0;
    end else begin
      st_r   <= st_nxt;
      done_r <= done_nxt;
    end
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
    r_r   <= r_nxt;
    bit_r <= bit_nxt;
    cnt_r <= cnt_nxt;
    rms_r <= rms_nxt;
  end

  assign done = done_r;
  assign rms  = rms_r;

`ifndef ASSERT_OFF
  a_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
    start |-> st_r == RT_IDLE) else $error("root start while busy");
  a_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |=> !done_r) else $error("root done held");
  a_rms_limit: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> rms_r <= RMS_LIMIT) else $error("root above full scale");
`endif

endmodule

@@ sv/audio_level_meter_dbfs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// audio_level_meter_dbfs
// RMS and peak level meter in 1/16 dBFS with quiet-floor tracking.
//
// in_ch carries beats of func/raw_word. A sample beat (func 0) takes the
// signed 24-bit sample from raw_word[31:8]; it passes through an accept and
// a square step, the sum add overlapping the next accept. A report tick
// (func 1) on a non-empty window runs a divide and a square root in
// alm_root, then two level conversions (leading-one search, scale and
// round), a floor multiply and the load into the output register.
// A tick on an empty window is dropped. in_ch.ready is low during the square
// cycle and while a tick is being worked on.
// out_ch holds one result in a register; while the receiver stalls, samples
// are still taken, and a following tick waits at the end for the register.
// cfg_we/cfg_index/cfg_data write one threshold a cycle; the user must do so
// only while idle; the block does not enforce it. Synchronous reset clears the
// window, the floor and the output valid, and restores the threshold defaults.
// ----------------------------------------------------------------------------
module audio_level_meter_dbfs #(
  parameter int COUNT_BITS     = alm_pkg::COUNT_BITS_DEF,
  parameter int LOG_TABLE_BITS = alm_pkg::LOG_TABLE_BITS_DEF
) (
  input  logic                            clk,
  input  logic                            rst_n,
  alm_in_if.sink                          in_ch,
  alm_out_if.source                       out_ch,
  input  logic                            cfg_we,
  input  logic [alm_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [alm_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import alm_pkg::*;

  localparam int TAB_N = 1 << LOG_TABLE_BITS;

  state_t                state_r, state_nxt;
  logic signed [11:0]    clip_r, clip_nxt, noise_r, noise_nxt;
  logic [10:0]           okd_r, okd_nxt, weakd_r, weakd_nxt;
  logic [63:0]           sum_r, sum_nxt;
  logic [COUNT_BITS-1:0] total_r, total_nxt, nz_r, nz_nxt;
  logic [23:0]           peak_r, peak_nxt;
  logic signed [11:0]    floor_r, floor_nxt;
  logic                  floor_ok_r, floor_ok_nxt;
  logic [23:0]           mag_r, mag_nxt;
  logic                  mag_nz_r, mag_nz_nxt;
  logic [47:0]           sq_r, sq_nxt;
  logic                  pend_r, pend_nxt;
  logic [23:0]           lv_v_r, lv_v_nxt;
  logic [4:0]            lv_e_r, lv_e_nxt;
  logic                  lv_sel_r, lv_sel_nxt;
  logic [43:0]           lv_prod_r, lv_prod_nxt;
  logic signed [11:0]    rms_db_r, rms_db_nxt, peak_db_r, peak_db_nxt;
  logic [23:0]           rms_r, rms_nxt;
  logic [29:0]           fprod_r, fprod_nxt;
  logic                  ov_r, ov_nxt;
  logic [23:0]           o_rms_r, o_rms_nxt;
  logic signed [11:0]    o_rdb_r, o_rdb_nxt, o_pdb_r, o_pdb_nxt;
  logic signed [11:0]    o_flr_r, o_flr_nxt, o_dlt_r, o_dlt_nxt;
  logic [17:0]           o_nz_r, o_nz_nxt, o_tot_r, o_tot_nxt;
  verdict_t              o_vd_r, o_vd_nxt;

  logic                  root_start, root_done;
  logic [23:0]           root_rms;
  logic [15:0]           frac_tab [TAB_N];

  logic                  in_beat;
  logic signed [23:0]    smp;
  logic [64:0]           acc_sum;
  logic                  lv_small;
  logic [LOG_TABLE_BITS-1:0] lv_idx;
  logic [20:0]           lv_d;
  logic [44:0]           lv_rsum;
  logic [10:0]           lv_q;
  logic signed [11:0]    lv_rnd_level, lv_level;
  logic                  lv_finish;
  logic signed [14:0]    fn_full;
  logic signed [12:0]    fdiv_s;
  logic signed [11:0]    floor_new, delta;
  logic signed [12:0]    delta_x;
  verdict_t              vd;

  // log2 fraction table, built at elaboration
  for (genvar g = 0; g < TAB_N; g++) begin : g_tab
    assign frac_tab[g] = alm_frac_entry(g, LOG_TABLE_BITS);
  end

  alm_root #(.COUNT_BITS(COUNT_BITS)) u_root (
    .clk   (clk),
    .rst_n (rst_n),
    .start (root_start),
    .sum   (sum_r),
    .count (total_r),
    .done  (root_done),
    .rms   (root_rms)
  );

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_beat     = in_ch.valid && in_ch.ready;
  assign smp         = in_ch.raw_word[31:8];
  assign acc_sum     = {1'b0, sum_r} + 65'(sq_r);

  // level datapath: leading-one search, table, scale and round
  assign lv_small     = (lv_v_r[23:1] == '0);
  assign lv_idx       = lv_v_r[22 -: LOG_TABLE_BITS];
  assign lv_d         = {5'(FS_LOG2) - lv_e_r, 16'd0} - 21'(frac_tab[lv_idx]);
  assign lv_rsum      = {1'b0, lv_prod_r} + (45'd1 << 31);
  assign lv_q         = (lv_rsum[44:32] > LEVEL_SAT) ? LEVEL_SAT[10:0] : lv_rsum[42:32];
  assign lv_rnd_level = -$signed({1'b0, lv_q});
  assign lv_level     = (state_r == ST_LV_RND) ? lv_rnd_level : LEVEL_MIN;
  assign lv_finish    = (state_r == ST_LV_RND) || (state_r == ST_LV_NORM && lv_small);

  // floor: first level, then floor((4*floor + level)/5) by reciprocal if lower
  assign fn_full   = 15'(4 * floor_r) + 15'(rms_db_r) + 15'sd10240;
  assign fdiv_s    = $signed({1'b0, fprod_r[29:18]}) - 13'sd2048;
  assign floor_new = !floor_ok_r ? rms_db_r :
                     (rms_db_r < floor_r) ? fdiv_s[11:0] : floor_r;
  assign delta     = rms_db_r - floor_new;
  assign delta_x   = {delta[11], delta};

  always_comb begin
    if (nz_r == '0)                               vd = VD_NO_DATA;
    else if (peak_db_r > clip_r)                  vd = VD_CLIP;
    else if (floor_new > noise_r)                 vd = VD_NOISY;
    else if (delta_x >= $signed({2'b00, okd_r}))  vd = VD_OK;
    else if (delta_x >= $signed({2'b00, weakd_r})) vd = VD_WEAK;
    else                                          vd = VD_WAIT;
  end

  always_comb begin
    state_nxt    = state_r;
    clip_nxt     = clip_r;
    noise_nxt    = noise_r;
    okd_nxt      = okd_r;
    weakd_nxt    = weakd_r;
    sum_nxt      = sum_r;
    total_nxt    = total_r;
    nz_nxt       = nz_r;
    peak_nxt     = peak_r;
    floor_nxt    = floor_r;
    floor_ok_nxt = floor_ok_r;
    mag_nxt      = mag_r;
    mag_nz_nxt   = mag_nz_r;
    sq_nxt       = sq_r;
    pend_nxt     = 1'b0;
    lv_v_nxt     = lv_v_r;
    lv_e_nxt     = lv_e_r;
    lv_sel_nxt   = lv_sel_r;
    lv_prod_nxt  = lv_prod_r;
    rms_db_nxt   = rms_db_r;
    peak_db_nxt  = peak_db_r;
    rms_nxt      = rms_r;
    fprod_nxt    = fprod_r;
    ov_nxt       = ov_r && !out_ch.ready;
    o_rms_nxt    = o_rms_r;
    o_rdb_nxt    = o_rdb_r;
    o_pdb_nxt    = o_pdb_r;
    o_flr_nxt    = o_flr_r;
    o_dlt_nxt    = o_dlt_r;
    o_nz_nxt     = o_nz_r;
    o_tot_nxt    = o_tot_r;
    o_vd_nxt     = o_vd_r;
    root_start   = 1'b0;

    // take configuration writes
    if (cfg_we) begin
      unique case (cfg_index)
        CFG_CLIP:  clip_nxt  = cfg_data;
        CFG_NOISE: noise_nxt = cfg_data;
        CFG_OK:    okd_nxt   = cfg_data[10:0];
        CFG_WEAK:  weakd_nxt = cfg_data[10:0];
        default:   ;
      endcase
    end

    // add the last square, saturating
    if (pend_r) begin
      sum_nxt = acc_sum[64] ? '1 : acc_sum[63:0];
    end

    // store a finished level and move on to the peak
    if (lv_finish) begin
      if (lv_sel_r) begin
        peak_db_nxt = lv_level;
      end else begin
        rms_db_nxt = lv_level;
      end
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_beat) begin
          if (!in_ch.func) begin
            mag_nxt    = smp[23] ? (~smp + 24'd1) : smp;
            mag_nz_nxt = (smp != '0);
            state_nxt  = ST_SQ;
          end else if (total_r != '0) begin
            state_nxt = ST_ROOT_GO;
          end
        end
      end
      ST_SQ: begin
        sq_nxt   = mag_r * mag_r;
        pend_nxt = 1'b1;
        if (total_r != '1) total_nxt = total_r + 1'b1;
        if (mag_nz_r && nz_r != '1) nz_nxt = nz_r + 1'b1;
        if (mag_r > peak_r) peak_nxt = mag_r;
        state_nxt = ST_IDLE;
      end
      ST_ROOT_GO: begin
        root_start = 1'b1;
        state_nxt  = ST_ROOT;
      end
      ST_ROOT: begin
        if (root_done) begin
          rms_nxt    = root_rms;
          lv_v_nxt   = root_rms;
          lv_e_nxt   = 5'(FS_LOG2);
          lv_sel_nxt = 1'b0;
          state_nxt  = ST_LV_NORM;
        end
      end
      ST_LV_NORM: begin
        if (lv_small) begin
          if (lv_sel_r) begin
            state_nxt = ST_FMUL;
          end else begin
            lv_v_nxt   = peak_r;
            lv_e_nxt   = 5'(FS_LOG2);
            lv_sel_nxt = 1'b1;
          end
        end else if (lv_v_r[23]) begin
          lv_prod_nxt = 44'(lv_d) * 44'(DB16_PER_OCT);
          state_nxt   = ST_LV_RND;
        end else begin
          lv_v_nxt = {lv_v_r[22:0], 1'b0};
          lv_e_nxt = lv_e_r - 5'd1;
        end
      end
      ST_LV_RND: begin
        if (lv_sel_r) begin
          state_nxt = ST_FMUL;
        end else begin
          lv_v_nxt   = peak_r;
          lv_e_nxt   = 5'(FS_LOG2);
          lv_sel_nxt = 1'b1;
          state_nxt  = ST_LV_NORM;
        end
      end
      ST_FMUL: begin
        fprod_nxt = 30'(fn_full[13:0]) * 30'(DIV5_RECIP);
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        // load the result once the output register is free, then clear
        if (!ov_r || out_ch.ready) begin
          ov_nxt       = 1'b1;
          o_rms_nxt    = rms_r;
          o_rdb_nxt    = rms_db_r;
          o_pdb_nxt    = peak_db_r;
          o_flr_nxt    = floor_new;
          o_dlt_nxt    = delta;
          o_nz_nxt     = 18'(nz_r);
          o_tot_nxt    = 18'(total_r);
          o_vd_nxt     = vd;
          floor_nxt    = floor_new;
          floor_ok_nxt = 1'b1;
          sum_nxt      = '0;
          total_nxt    = '0;
          nz_nxt       = '0;
          peak_nxt     = '0;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      clip_r     <= -12'sd16;
      noise_r    <= -12'sd320;
      okd_r      <= 11'd192;
      weakd_r    <= 11'd96;
      sum_r      <= '0;
      total_r    <= '0;
      nz_r       <= '0;
      peak_r     <= '0;
      floor_r    <= '0;
      floor_ok_r <= 1'b0;
      pend_r     <= 1'b0;
      ov_r       <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      clip_r     <= clip_nxt;
      noise_r    <= noise_nxt;
      okd_r      <= okd_nxt;
      weakd_r    <= weakd_nxt;
      sum_r      <= sum_nxt;
      total_r    <= total_nxt;
      nz_r       <= nz_nxt;
      peak_r     <= peak_nxt;
      floor_r    <= floor_nxt;
      floor_ok_r <= floor_ok_nxt;
      pend_r     <= pend_nxt;
      ov_r       <= ov_nxt;
    end
    mag_r     <= mag_nxt;
    mag_nz_r  <= mag_nz_nxt;
    sq_r      <= sq_nxt;
    lv_v_r    <= lv_v_nxt;
    lv_e_r    <= lv_e_nxt;
    lv_sel_r  <= lv_sel_nxt;
    lv_prod_r <= lv_prod_nxt;
    rms_db_r  <= rms_db_nxt;
    peak_db_r <= peak_db_nxt;
    rms_r     <= rms_nxt;
    fprod_r   <= fprod_nxt;
    o_rms_r   <= o_rms_nxt;
    o_rdb_r   <= o_rdb_nxt;
    o_pdb_r   <= o_pdb_nxt;
    o_flr_r   <= o_flr_nxt;
    o_dlt_r   <= o_dlt_nxt;
    o_nz_r    <= o_nz_nxt;
    o_tot_r   <= o_tot_nxt;
    o_vd_r    <= o_vd_nxt;
  end

  assign out_ch.valid           = ov_r;
  assign out_ch.rms_value       = o_rms_r;
  assign out_ch.rms_level       = o_rdb_r;
  assign out_ch.peak_level      = o_pdb_r;
  assign out_ch.noise_floor     = o_flr_r;
  assign out_ch.level_rise      = o_dlt_r;
  assign out_ch.nonzero_samples = o_nz_r;
  assign out_ch.window_samples  = o_tot_r;
  assign out_ch.verdict         = o_vd_r;

`ifndef ASSERT_OFF
  a_sample_sq: assert property (@(posedge clk) disable iff (!rst_n)
    (in_beat && !in_ch.func) |=> state_r == ST_SQ) else $error("sample not squared");
  a_done_root: assert property (@(posedge clk) disable iff (!rst_n)
    root_done |-> state_r == ST_ROOT) else $error("root result outside wait");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_OUT && state_nxt == ST_IDLE) |=> (total_r == '0 && out_ch.valid))
    else $error("window not cleared on result");
  a_level: assert property (@(posedge clk) disable iff (!rst_n)
    out_ch.valid |-> (out_ch.rms_level <= 0 && out_ch.rms_level >= -1920))
    else $error("rms level out of range");
`endif

endmodule
